@@ design/keyframe_vector_interpolator_top_assert.svh @@
// ============================================================================
// keyframe_vector_interpolator_top_assert.svh
// Assertion macros shared by the checker of the keyframe interpolator.
// ============================================================================
`ifndef KEYFRAME_VECTOR_INTERPOLATOR_TOP_ASSERT_SVH
`define KEYFRAME_VECTOR_INTERPOLATOR_TOP_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define KVI_CHECK_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define KVI_CHECK_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/kvi_pkg.sv @@
// ============================================================================
// kvi_pkg
// Types, sizes and codes of the keyframe vector interpolator.
// ============================================================================
package kvi_pkg;

    localparam int MAX_KEYS  = 16;
    localparam int KEY_AW    = $clog2(MAX_KEYS);
    localparam int CNT_W     = 5;
    localparam int DATA_W    = 32;
    localparam int PADDR_W   = 3;
    localparam int DIV_STEPS = 32;
    localparam int DIV_CW    = $clog2(DIV_STEPS);

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // register index bit of paddr
    localparam logic REG_KEY_COUNT = 1'b0;

    localparam logic [1:0] COMP_X = 2'd0;
    localparam logic [1:0] COMP_Y = 2'd1;
    localparam logic [1:0] COMP_Z = 2'd2;

    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] z;
    } vec_t;

    typedef struct packed {
        logic [DATA_W-1:0] key_time;
        vec_t              vec;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH0,
        ST_FIRST,
        ST_SCAN,
        ST_DIV,
        ST_LERP,
        ST_EMIT
    } state_t;

endpackage

@@ design/kvi_if.sv @@
// ============================================================================
// kvi_if
// Request and response channels of the keyframe vector interpolator.
// ============================================================================
interface kvi_req_if;
    import kvi_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     req_type;
    logic [3:0]               key_index;
    logic [DATA_W-1:0]        key_time;
    logic signed [DATA_W-1:0] key_x;
    logic signed [DATA_W-1:0] key_y;
    logic signed [DATA_W-1:0] key_z;
    logic [DATA_W-1:0]        query_time;

    modport source (
        output valid, req_type, key_index, key_time, key_x, key_y, key_z, query_time,
        input  ready
    );
    modport sink (
        input  valid, req_type, key_index, key_time, key_x, key_y, key_z, query_time,
        output ready
    );
endinterface

interface kvi_rsp_if;
    import kvi_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] out_x;
    logic signed [DATA_W-1:0] out_y;
    logic signed [DATA_W-1:0] out_z;
    logic                     is_answer;

    modport source (
        output valid, out_x, out_y, out_z, is_answer,
        input  ready
    );
    modport sink (
        input  valid, out_x, out_y, out_z, is_answer,
        output ready
    );
endinterface

@@ design/kvi_ram.sv @@
// ============================================================================
// kvi_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module kvi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

@@ design/kvi_div.sv @@
// ============================================================================
// kvi_div
// Radix-2 restoring divider: quot = floor(num * 2^31 / den), num <= den.
// ============================================================================
module kvi_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [kvi_pkg::DATA_W-1:0] num,
    input  logic [kvi_pkg::DATA_W-1:0] den,
    output logic                      done,
    output logic [kvi_pkg::DATA_W-1:0] quot
);
    import kvi_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic [DATA_W:0]   rem_reg;
    logic [DATA_W-1:0] den_reg;
    logic [DATA_W-1:0] quot_reg;

    logic              ge;
    logic [DATA_W:0]   diff;

    always_comb
    begin
        ge   = rem_reg >= {1'b0, den_reg};
        diff = ge ? (rem_reg - {1'b0, den_reg}) : rem_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                // equal pair times: fraction is zero, no iterations
                busy_reg <= (den != '0);
                done_reg <= (den == '0);
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + DIV_CW'(1);
                if (cnt_reg == DIV_CW'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= {1'b0, num};
            den_reg  <= den;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= {diff[DATA_W-1:0], 1'b0};
            quot_reg <= {quot_reg[DATA_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

@@ design/kvi_lerp.sv @@
// ============================================================================
// kvi_lerp
// Three-component lerp through one shared multiplier, one component a cycle.
// ============================================================================
module kvi_lerp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [kvi_pkg::DATA_W-1:0] frac,
    input  kvi_pkg::vec_t              va,
    input  kvi_pkg::vec_t              vb,
    output logic                       done,
    output kvi_pkg::vec_t              res
);
    import kvi_pkg::*;

    function automatic logic signed [DATA_W-1:0] pick(input vec_t v, input logic [1:0] c);
        logic signed [DATA_W-1:0] r;
        case (c)
            COMP_X:  r = v.x;
            COMP_Y:  r = v.y;
            default: r = v.z;
        endcase
        return r;
    endfunction

    vec_t               a_reg;
    vec_t               b_reg;
    vec_t               res_reg;
    logic [DATA_W-1:0]  f_reg;
    logic               iss_act_reg;
    logic [1:0]         iss_reg;
    logic               s1_vld_reg;
    logic [1:0]         s1_c_reg;
    logic signed [DATA_W:0]   d_reg;
    logic signed [DATA_W-1:0] v0_s1_reg;
    logic               s2_vld_reg;
    logic [1:0]         s2_c_reg;
    logic [63:0]        prod_reg;
    logic signed [DATA_W-1:0] v0_s2_reg;
    logic               done_reg;

    logic signed [DATA_W-1:0] a_c;
    logic signed [DATA_W-1:0] b_c;
    logic signed [DATA_W:0]   d_next;
    logic signed [2*DATA_W+1:0] mult_full;
    logic [63:0]        rnd_sum;
    logic signed [DATA_W-1:0] comp_next;

    always_comb
    begin
        a_c       = pick(a_reg, iss_reg);
        b_c       = pick(b_reg, iss_reg);
        d_next    = {b_c[DATA_W-1], b_c} - {a_c[DATA_W-1], a_c};
        mult_full = d_reg * $signed({1'b0, f_reg});
        rnd_sum   = prod_reg + 64'h0000_0000_4000_0000;
        comp_next = v0_s2_reg + $signed(rnd_sum[62:31]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iss_act_reg <= 1'b0;
            iss_reg     <= '0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= iss_act_reg;
            s2_vld_reg <= s1_vld_reg;
            done_reg   <= s2_vld_reg && (s2_c_reg == COMP_Z);
            if (start)
            begin
                iss_act_reg <= 1'b1;
                iss_reg     <= COMP_X;
            end
            else if (iss_act_reg)
            begin
                iss_reg <= iss_reg + 2'd1;
                if (iss_reg == COMP_Z)
                begin
                    iss_act_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= va;
            b_reg <= vb;
            f_reg <= frac;
        end
        s1_c_reg  <= iss_reg;
        d_reg     <= d_next;
        v0_s1_reg <= a_c;
        s2_c_reg  <= s1_c_reg;
        prod_reg  <= mult_full[63:0];
        v0_s2_reg <= v0_s1_reg;
        if (s2_vld_reg)
        begin
            case (s2_c_reg)
                COMP_X:  res_reg.x <= comp_next;
                COMP_Y:  res_reg.y <= comp_next;
                default: res_reg.z <= comp_next;
            endcase
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

@@ design/keyframe_vector_interpolator_top.sv @@
// ============================================================================
// keyframe_vector_interpolator_top
// Piecewise linear interpolation over a table of Q16.16 (time, x, y, z) keys.
// ============================================================================
//  channel  dir   handshake               payload
//  req      in    valid/ready             req_type key_index key_time key_x/y/z query_time
//  rsp      out   valid/ready             out_x out_y out_z is_answer
//  apb      cfg   psel/penable, pready=1  key_count at byte address 0
//
//  Load: one transfer in, then through ST_EMIT into the output register.
//  Query: key table walked one entry a cycle from the key RAM read port;
//  a bracketing pair then adds serial division and the three products
//  through one multiplier.
//  Reset clears control and sets key_count to 1; no table clearing pass.
//  A new request is taken once the previous result sits in the output register.
module keyframe_vector_interpolator_top (
    input  logic                        clk,
    input  logic                        rst_n,
    kvi_req_if.sink                     req,
    kvi_rsp_if.source                   rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [kvi_pkg::PADDR_W-1:0] paddr,
    input  logic [kvi_pkg::DATA_W-1:0]  pwdata,
    output logic [kvi_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import kvi_pkg::*;

    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  key_count_reg;
    logic [KEY_AW-1:0] idx_reg;
    logic [DATA_W-1:0] t_reg;
    entry_t            prev_reg;
    entry_t            cur_reg;
    vec_t              res_reg;
    logic              ans_reg;
    vec_t              out_reg;
    logic              out_ans_reg;
    logic              out_vld_reg;

    logic [KEY_AW-1:0] last_idx;
    logic [KEY_AW-1:0] rd_addr;
    logic [KEY_AW-1:0] wr_addr;
    entry_t            rd_data;
    entry_t            wr_data;
    logic              wr_en;
    logic              in_acc;
    logic              cfg_we;
    logic              load_out;
    logic              div_start;
    logic              div_done;
    logic [DATA_W-1:0] div_quot;
    logic              lerp_start;
    logic              lerp_done;
    vec_t              lerp_res;
    logic              bracket;
    logic              first_hit;
    logic [DATA_W-1:0] num;
    logic [DATA_W-1:0] den;

    // configuration
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[PADDR_W-1])
            REG_KEY_COUNT: prdata = DATA_W'(key_count_reg);
            default:       prdata = '0;
        endcase
    end

    always_comb
    begin
        if (key_count_reg == '0)
        begin
            last_idx = '0;
        end
        else if (32'(key_count_reg) > MAX_KEYS)
        begin
            last_idx = KEY_AW'(MAX_KEYS - 1);
        end
        else
        begin
            last_idx = KEY_AW'(key_count_reg - CNT_W'(1));
        end
    end

    // key table
    assign in_acc  = req.valid && req.ready;
    assign wr_en   = in_acc && (req.req_type == REQ_LOAD) && (32'(req.key_index) < MAX_KEYS);
    assign wr_addr = KEY_AW'(req.key_index);
    assign wr_data = '{key_time: req.key_time,
                       vec: '{x: req.key_x, y: req.key_y, z: req.key_z}};

    kvi_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (MAX_KEYS)
    ) u_key_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign bracket   = (prev_reg.key_time <= t_reg) && (t_reg <= rd_data.key_time);
    assign first_hit = (last_idx == '0) || (t_reg <= rd_data.key_time);
    assign num       = t_reg - prev_reg.key_time;
    assign den       = rd_data.key_time - prev_reg.key_time;

    kvi_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num),
        .den   (den),
        .done  (div_done),
        .quot  (div_quot)
    );

    kvi_lerp u_lerp (
        .clk   (clk),
        .rst_n (rst_n),
        .start (lerp_start),
        .frac  (div_quot),
        .va    (prev_reg.vec),
        .vb    (cur_reg.vec),
        .done  (lerp_done),
        .res   (lerp_res)
    );

    // sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = (req.req_type == REQ_LOAD) ? ST_EMIT : ST_FETCH0;
                end
            end
            ST_FETCH0: state_next = ST_FIRST;
            ST_FIRST:  state_next = first_hit ? ST_EMIT : ST_SCAN;
            ST_SCAN:
            begin
                if (bracket)
                begin
                    state_next = ST_DIV;
                end
                else if (idx_reg == last_idx)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_LERP;
                end
            end
            ST_LERP:
            begin
                if (lerp_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer: outputs
    always_comb
    begin
        req.ready  = 1'b0;
        rd_addr    = '0;
        div_start  = 1'b0;
        lerp_start = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE:   req.ready = 1'b1;
            ST_FETCH0: rd_addr = '0;
            ST_FIRST:  rd_addr = KEY_AW'(1);
            ST_SCAN:
            begin
                rd_addr   = idx_reg + KEY_AW'(1);
                div_start = bracket;
            end
            ST_DIV:    lerp_start = div_done;
            ST_LERP:   lerp_start = 1'b0;
            ST_EMIT:   load_out = !out_vld_reg || rsp.ready;
            default:   load_out = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            key_count_reg <= CNT_W'(1);
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we && (paddr[PADDR_W-1] == REG_KEY_COUNT))
            begin
                key_count_reg <= pwdata[CNT_W-1:0];
            end
            if (load_out)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            t_reg   <= req.query_time;
            ans_reg <= (req.req_type == REQ_QUERY);
            res_reg <= '0;
        end
        case (state_reg)
            ST_FIRST:
            begin
                prev_reg <= rd_data;
                res_reg  <= rd_data.vec;
                idx_reg  <= KEY_AW'(1);
            end
            ST_SCAN:
            begin
                if (bracket)
                begin
                    cur_reg <= rd_data;
                end
                else
                begin
                    prev_reg <= rd_data;
                    res_reg  <= rd_data.vec;
                    idx_reg  <= idx_reg + KEY_AW'(1);
                end
            end
            ST_LERP:
            begin
                if (lerp_done)
                begin
                    res_reg <= lerp_res;
                end
            end
            default:
            begin
            end
        endcase
        if (load_out)
        begin
            out_reg     <= res_reg;
            out_ans_reg <= ans_reg;
        end
    end

    assign rsp.valid     = out_vld_reg;
    assign rsp.out_x     = out_reg.x;
    assign rsp.out_y     = out_reg.y;
    assign rsp.out_z     = out_reg.z;
    assign rsp.is_answer = out_ans_reg;

endmodule

@@ design/kvi_checker.sv @@
// ============================================================================
// kvi_checker
// Port-level checks of the keyframe vector interpolator, bound to the top.
// ============================================================================
`include "keyframe_vector_interpolator_top_assert.svh"

module kvi_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [kvi_pkg::DATA_W-1:0]  out_x,
    input logic [kvi_pkg::DATA_W-1:0]  out_y,
    input logic [kvi_pkg::DATA_W-1:0]  out_z,
    input logic                        is_answer,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic [kvi_pkg::PADDR_W-1:0] paddr,
    input logic [kvi_pkg::DATA_W-1:0]  pwdata,
    input logic [kvi_pkg::DATA_W-1:0]  prdata
);
    import kvi_pkg::*;

    // stalled result holds
    `KVI_CHECK_NEXT(a_rsp_hold, out_valid && !out_ready, out_valid && $stable(out_x) && $stable(out_y) && $stable(out_z) && $stable(is_answer), "stalled response changed")

    // one request in flight at a time
    `KVI_CHECK_NEXT(a_one_item, in_valid && in_ready, !in_ready, "request taken while busy")

    // load acknowledge carries a zero vector
    `KVI_CHECK_SAME(a_ack_zero, out_valid && !is_answer, (out_x == '0) && (out_y == '0) && (out_z == '0), "load ack with nonzero data")

    // key_count reads back what was written
    `KVI_CHECK_SAME(a_cfg_readback, $past(rst_n) && $past(psel && penable && pwrite && (paddr[PADDR_W-1] == REG_KEY_COUNT)) && (paddr[PADDR_W-1] == REG_KEY_COUNT), prdata[CNT_W-1:0] == $past(pwdata[CNT_W-1:0]), "key_count readback mismatch")

endmodule

bind keyframe_vector_interpolator_top kvi_checker u_kvi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_x     (rsp.out_x),
    .out_y     (rsp.out_y),
    .out_z     (rsp.out_z),
    .is_answer (rsp.is_answer),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata)
);
